[src/ptc_pkg.sv]
`default_nettype none

package ptc_pkg;

	// register and field widths
	localparam int CFG_W   = 11;
	localparam int RAD_W   = 10;
	localparam int IDX_W   = 3;
	localparam int SPEED_W = 13;

	// register indexes on the configuration port
	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_X  = 3'd0,
		REG_CENTER_Y  = 3'd1,
		REG_MAX_AZ    = 3'd2,
		REG_MAX_EL    = 3'd3,
		REG_INNER_RAD = 3'd4,
		REG_OUTER_RAD = 3'd5
	} reg_idx_t;

	// register reset values
	localparam logic [CFG_W-1:0] CENTER_X_RST  = 11'd320;
	localparam logic [CFG_W-1:0] CENTER_Y_RST  = 11'd240;
	localparam logic [RAD_W-1:0] MAX_SPEED_RST = 10'd250;
	localparam logic [RAD_W-1:0] INNER_RST     = 10'd20;
	localparam logic [RAD_W-1:0] OUTER_RST     = 10'd50;

	// saturation limits of a speed field
	localparam logic [SPEED_W-1:0] SPEED_MAX = 13'h0FFF;
	localparam logic [SPEED_W-1:0] SPEED_MIN = 13'h1000;

	// sequencing of a serial unit
	typedef struct packed {
		logic load;
		logic step;
	} ptc_ctl_t;

endpackage

`default_nettype wire

[src/ptc_mul.sv]
`default_nettype none

// shift-add multiplier, one multiplier bit per step, lsb first
module ptc_mul #(
	parameter int AW = 10,
	parameter int BW = 10
) (
	input  wire logic               clk,
	input  wire ptc_pkg::ptc_ctl_t  ctl,
	input  wire logic [AW-1:0]      a,
	input  wire logic [BW-1:0]      b,
	output logic      [AW+BW-1:0]   p
);

	localparam int PW = AW + BW;

	logic [PW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [PW-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q   <= PW'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (ctl.step) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign p = acc_q;

endmodule

`default_nettype wire

[src/ptc_div.sv]
`default_nettype none

// restoring divider, one quotient bit per step, msb first
module ptc_div #(
	parameter int NW = 23,
	parameter int DW = 11
) (
	input  wire logic               clk,
	input  wire ptc_pkg::ptc_ctl_t  ctl,
	input  wire logic [NW-1:0]      num,
	input  wire logic [DW-1:0]      den,
	output logic      [NW-1:0]      quo
);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] n_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, n_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			n_q   <= num;
			den_q <= den;
		end else if (ctl.step) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			n_q   <= {n_q[NW-2:0], ge};
		end
	end

	// quotient bits shift in behind the dividend
	assign quo = n_q;

endmodule

`default_nettype wire

[src/pan_tilt_centering_with_hysteresis.sv]
// a speed command runs setup, the bit-serial multiply, compare, the bit-serial divide,
// saturate and output after the input transfer; the block takes a new item only in idle,
// once the last one is through; lost or in-band items finish sooner: a stop for a lost
// object goes from setup straight to output, a stop inside the band from compare to
// output; a busy output register adds its stall
// reset: arst_n asynchronous active low; registers return to defaults, camera idle
`default_nettype none

module pan_tilt_centering_with_hysteresis #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	// configuration write port
	input  wire logic                                           cfg_we,
	input  wire logic [ptc_pkg::IDX_W-1:0]                      cfg_index,
	input  wire logic [ptc_pkg::CFG_W-1:0]                      cfg_data,
	// tracking result input
	input  wire logic                                           s_tvalid,
	output logic                                                s_tready,
	// object_found, box_left, box_top, box_width, box_height, zero pad
	input  wire logic [((1+4*COORD_BITS+7)/8)*8-1:0]            s_tdata,
	// speed command output
	output logic                                                m_tvalid,
	input  wire logic                                           m_tready,
	// azimuth_speed, elevation_speed, zero pad
	output logic [((2*ptc_pkg::SPEED_W+7)/8)*8-1:0]             m_tdata
);

	localparam int C     = COORD_BITS;
	localparam int CW_R  = ptc_pkg::CFG_W;
	localparam int RW    = ptc_pkg::RAD_W;
	localparam int SPW   = ptc_pkg::SPEED_W;
	localparam int OW    = C + 1;                    // object centre width
	localparam int MW    = (OW > CW_R) ? OW : CW_R;  // offset magnitude width
	localparam int SW    = 2 * MW;                   // squared offset width
	localparam int D2W   = SW + 1;                   // squared distance width
	localparam int NW    = MW + RW;                  // offset times max speed
	localparam int CNTW  = $clog2(NW + 1);
	localparam int OUT_W = ((2*SPW+7)/8)*8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_SAT,
		ST_OUT
	} state_t;

	// configuration registers
	logic [CW_R-1:0] cx_q;
	logic [CW_R-1:0] cy_q;
	logic [RW-1:0]   max_az_q;
	logic [RW-1:0]   max_el_q;
	logic [RW-1:0]   inner_q;
	logic [RW-1:0]   outer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= ptc_pkg::CENTER_X_RST;
			cy_q     <= ptc_pkg::CENTER_Y_RST;
			max_az_q <= ptc_pkg::MAX_SPEED_RST;
			max_el_q <= ptc_pkg::MAX_SPEED_RST;
			inner_q  <= ptc_pkg::INNER_RST;
			outer_q  <= ptc_pkg::OUTER_RST;
		end else if (cfg_we) begin
			case (ptc_pkg::reg_idx_t'(cfg_index))
				ptc_pkg::REG_CENTER_X:  cx_q     <= cfg_data;
				ptc_pkg::REG_CENTER_Y:  cy_q     <= cfg_data;
				ptc_pkg::REG_MAX_AZ:    max_az_q <= cfg_data[RW-1:0];
				ptc_pkg::REG_MAX_EL:    max_el_q <= cfg_data[RW-1:0];
				ptc_pkg::REG_INNER_RAD: inner_q  <= cfg_data[RW-1:0];
				ptc_pkg::REG_OUTER_RAD: outer_q  <= cfg_data[RW-1:0];
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// input field unpacking
	logic          in_found;
	logic [C-1:0]  in_left;
	logic [C-1:0]  in_top;
	logic [C-1:0]  in_width;
	logic [C-1:0]  in_height;

	assign in_found  = s_tdata[0];
	assign in_left   = s_tdata[C:1];
	assign in_top    = s_tdata[2*C:C+1];
	assign in_width  = s_tdata[3*C:2*C+1];
	assign in_height = s_tdata[4*C:3*C+1];

	// object centre and signed offset from frame centre, split into sign and magnitude
	logic [OW-1:0] ox;
	logic [OW-1:0] oy;
	logic [MW:0]   dx;
	logic [MW:0]   dy;
	logic [MW:0]   dx_abs;
	logic [MW:0]   dy_abs;

	assign ox     = OW'(in_left) + OW'(in_width >> 1);
	assign oy     = OW'(in_top) + OW'(in_height >> 1);
	assign dx     = (MW+1)'(cx_q) - (MW+1)'(ox);
	assign dy     = (MW+1)'(cy_q) - (MW+1)'(oy);
	assign dx_abs = dx[MW] ? ((MW+1)'(0) - dx) : dx;
	assign dy_abs = dy[MW] ? ((MW+1)'(0) - dy) : dy;

	state_t            state_q;
	logic              moving_q;
	logic [CNTW-1:0]   cnt_q;
	logic              found_q;
	logic              sx_q;
	logic              sy_q;
	logic [MW-1:0]     mx_q;
	logic [MW-1:0]     my_q;
	logic [2*SPW-1:0]  res_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	// serial unit sequencing
	ptc_pkg::ptc_ctl_t mul_ctl;
	ptc_pkg::ptc_ctl_t div_ctl;
	logic [RW-1:0]     radius;
	logic [SW-1:0]     pxx;
	logic [SW-1:0]     pyy;
	logic [2*RW-1:0]   prr;
	logic [NW-1:0]     pxs;
	logic [NW-1:0]     pys;
	logic [NW-1:0]     qx;
	logic [NW-1:0]     qy;
	logic [D2W-1:0]    d2;
	logic              beyond;

	// hysteresis: the stop radius applies while moving, the start radius while idle
	assign radius = moving_q ? inner_q : outer_q;

	assign mul_ctl.load = (state_q == ST_SETUP) && found_q;
	assign mul_ctl.step = (state_q == ST_MUL);

	assign d2     = D2W'(pxx) + D2W'(pyy);
	assign beyond = d2 > D2W'(prr);

	assign div_ctl.load = (state_q == ST_CMP) && beyond;
	assign div_ctl.step = (state_q == ST_DIV);

	// squares and speed products share the offset magnitude as serial multiplier
	ptc_mul #(.AW(MW), .BW(MW)) u_mul_xx (
		.clk (clk), .ctl (mul_ctl), .a (mx_q), .b (mx_q), .p (pxx)
	);
	ptc_mul #(.AW(MW), .BW(MW)) u_mul_yy (
		.clk (clk), .ctl (mul_ctl), .a (my_q), .b (my_q), .p (pyy)
	);
	ptc_mul #(.AW(RW), .BW(MW)) u_mul_xs (
		.clk (clk), .ctl (mul_ctl), .a (max_az_q), .b (mx_q), .p (pxs)
	);
	ptc_mul #(.AW(RW), .BW(MW)) u_mul_ys (
		.clk (clk), .ctl (mul_ctl), .a (max_el_q), .b (my_q), .p (pys)
	);
	// radius square runs the same step count, extra steps see zero bits
	ptc_mul #(.AW(RW), .BW(RW)) u_mul_rr (
		.clk (clk), .ctl (mul_ctl), .a (radius), .b (radius), .p (prr)
	);

	ptc_div #(.NW(NW), .DW(CW_R)) u_div_x (
		.clk (clk), .ctl (div_ctl), .num (pxs), .den (cx_q), .quo (qx)
	);
	ptc_div #(.NW(NW), .DW(CW_R)) u_div_y (
		.clk (clk), .ctl (div_ctl), .num (pys), .den (cy_q), .quo (qy)
	);

	// apply sign to the truncated quotient magnitude and clamp to the field range; a zero frame centre gives zero speed
	function automatic logic [SPW-1:0] sat_speed(
		input logic          zero_den,
		input logic          neg,
		input logic [NW-1:0] q
	);
		logic pos_over;
		logic neg_over;
		logic [SPW-1:0] r;
		pos_over = |q[NW-1:SPW-1];
		neg_over = (|q[NW-1:SPW]) || (q[SPW-1] && (|q[SPW-2:0]));
		if (zero_den) begin
			r = '0;
		end else if (!neg) begin
			r = pos_over ? ptc_pkg::SPEED_MAX : q[SPW-1:0];
		end else begin
			r = neg_over ? ptc_pkg::SPEED_MIN : (SPW'(0) - q[SPW-1:0]);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			moving_q   <= 1'b0;
			cnt_q      <= '0;
			found_q    <= 1'b0;
			sx_q       <= 1'b0;
			sy_q       <= 1'b0;
			mx_q       <= '0;
			my_q       <= '0;
			res_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// a transfer empties the output register unless a new command refills it
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						found_q <= in_found;
						sx_q    <= dx[MW];
						sy_q    <= dy[MW];
						mx_q    <= dx_abs[MW-1:0];
						my_q    <= dy_abs[MW-1:0];
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					cnt_q <= '0;
					if (found_q) begin
						state_q <= ST_MUL;
					end else if (moving_q) begin
						// object lost while moving: stop command
						moving_q <= 1'b0;
						res_q    <= '0;
						state_q  <= ST_OUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					if (cnt_q == CNTW'(MW-1)) begin
						state_q <= ST_CMP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CMP: begin
					cnt_q <= '0;
					if (beyond) begin
						moving_q <= 1'b1;
						state_q  <= ST_DIV;
					end else if (moving_q) begin
						// back inside the band: stop command
						moving_q <= 1'b0;
						res_q    <= '0;
						state_q  <= ST_OUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNTW'(NW-1)) begin
						state_q <= ST_SAT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SAT: begin
					res_q   <= {sat_speed(cy_q == '0, sy_q, qy),
					            sat_speed(cx_q == '0, sx_q, qx)};
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// wait for the output register to free up
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OUT_W'(res_q);
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	// speed division only runs once the camera has been marked moving
	a_div_moving: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> moving_q)
		else $error("divide running while camera idle");

	// an accepted item always starts the sequence
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SETUP))
		else $error("accepted item did not start sequence");

	// a lost object while moving gives a stop command and clears the flag
	a_lost_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP && !found_q && moving_q) |=>
		(state_q == ST_OUT && res_q == '0 && !moving_q))
		else $error("lost object did not stop camera");

	// step counter stays inside the multiply length
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cnt_q < CNTW'(MW)))
		else $error("multiply step counter out of range");
`endif

endmodule

`default_nettype wire
